>>> rtl/core/greek_byte_transliterator_unit_macros.svh
// Assertion helpers shared by the transliterator modules.
`ifndef GREEK_BYTE_TRANSLITERATOR_UNIT_MACROS_SVH
`define GREEK_BYTE_TRANSLITERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gbt_pkg.sv
`default_nettype none
package gbt_pkg;

	localparam int RUN_CHARS   = 4;
	localparam int TEXT_CHARS  = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CTRL_LIMIT = 8'd32;
	localparam logic [7:0] CAP_MU     = 8'd204;
	localparam logic [7:0] CAP_NU     = 8'd205;
	localparam logic [7:0] SMALL_MU   = 8'd236;
	localparam logic [7:0] SMALL_NU   = 8'd237;
	localparam logic [7:0] CAP_PI     = 8'd208;
	localparam logic [7:0] SMALL_PI   = 8'd240;
	localparam logic [7:0] CAP_TAU    = 8'd212;
	localparam logic [7:0] SMALL_TAU  = 8'd244;

	typedef struct packed {
		logic [1:0]                  len;
		logic [TEXT_CHARS-1:0][7:0]  chr;
	} text_t;

	typedef struct packed {
		logic [2:0]                  cnt;
		logic [RUN_CHARS-1:0][7:0]   chr;
	} run_t;

	function automatic text_t txt1(input logic [7:0] a);
		text_t t;
		t.len    = 2'd1;
		t.chr[0] = a;
		t.chr[1] = 8'd0;
		t.chr[2] = 8'd0;
		return t;
	endfunction

	function automatic text_t txt2(input logic [7:0] a, input logic [7:0] b);
		text_t t;
		t.len    = 2'd2;
		t.chr[0] = a;
		t.chr[1] = b;
		t.chr[2] = 8'd0;
		return t;
	endfunction

	function automatic text_t txt3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		text_t t;
		t.len    = 2'd3;
		t.chr[0] = a;
		t.chr[1] = b;
		t.chr[2] = c;
		return t;
	endfunction

	// Latin text for one ISO-8859-7 byte; unmapped bytes stand for themselves.
	function automatic text_t map_text(input logic [7:0] c);
		text_t t;
		case (c)
			8'd193: t = txt1("A");
			8'd194: t = txt1("V");
			8'd195: t = txt1("G");
			8'd196: t = txt1("D");
			8'd197: t = txt1("E");
			8'd198: t = txt1("Z");
			8'd199: t = txt1("H");
			8'd200: t = txt1("8");
			8'd201: t = txt1("I");
			8'd202: t = txt1("K");
			8'd203: t = txt1("L");
			8'd204: t = txt1("M");
			8'd205: t = txt1("N");
			8'd206: t = txt2("K", "S");
			8'd207: t = txt1("O");
			8'd208: t = txt1("P");
			8'd209: t = txt1("R");
			8'd211: t = txt1("S");
			8'd212: t = txt1("T");
			8'd213: t = txt1("Y");
			8'd214: t = txt1("F");
			8'd215: t = txt1("X");
			8'd216: t = txt2("P", "S");
			8'd217: t = txt1("W");
			8'd225: t = txt1("a");
			8'd226: t = txt1("v");
			8'd227: t = txt1("g");
			8'd228: t = txt1("d");
			8'd229: t = txt1("e");
			8'd230: t = txt1("z");
			8'd231: t = txt1("h");
			8'd232: t = txt1("8");
			8'd233: t = txt1("i");
			8'd234: t = txt1("k");
			8'd235: t = txt1("l");
			8'd236: t = txt1("m");
			8'd237: t = txt1("n");
			8'd238: t = txt2("k", "s");
			8'd239: t = txt1("o");
			8'd240: t = txt1("p");
			8'd241: t = txt1("r");
			8'd242: t = txt1("s");
			8'd243: t = txt1("s");
			8'd244: t = txt1("t");
			8'd245: t = txt1("y");
			8'd246: t = txt1("f");
			8'd247: t = txt1("x");
			8'd248: t = txt2("p", "s");
			8'd249: t = txt1("w");
			8'd182: t = txt2("'", "A");
			8'd184: t = txt2("'", "E");
			8'd185: t = txt2("'", "H");
			8'd186: t = txt2("'", "I");
			8'd188: t = txt2("'", "O");
			8'd191: t = txt2("'", "W");
			8'd190: t = txt2("'", "Y");
			8'd220: t = txt2("a", "'");
			8'd221: t = txt2("e", "'");
			8'd222: t = txt2("h", "'");
			8'd223: t = txt2("i", "'");
			8'd252: t = txt2("o", "'");
			8'd254: t = txt2("w", "'");
			8'd253: t = txt2("y", "'");
			8'd250: t = txt2("i", "\"");
			8'd251: t = txt2("y", "\"");
			8'd192: t = txt3("i", "'", "\"");
			8'd224: t = txt3("y", "'", "\"");
			default: t = txt1(c);
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/gbt_front.sv
`default_nettype none
module gbt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [7:0]    in_byte,
	input  wire logic          q_full,
	output logic               q_push,
	output gbt_pkg::run_t      q_data
);

	typedef enum logic [2:0] {
		HELD_NONE,
		HELD_SMALL_MU,
		HELD_CAP_MU,
		HELD_SMALL_NU,
		HELD_CAP_NU
	} held_t;

	held_t           held_q;
	held_t           held_next;
	gbt_pkg::text_t  txt;
	logic            ctrl;
	logic            is_pi;
	logic            is_tau;
	logic            rel;
	logic [7:0]      rel_char;
	logic            accept;
	logic            takes_hold;

	assign ctrl   = in_byte < gbt_pkg::CTRL_LIMIT;
	assign is_pi  = (in_byte == gbt_pkg::SMALL_PI) || (in_byte == gbt_pkg::CAP_PI);
	assign is_tau = (in_byte == gbt_pkg::SMALL_TAU) || (in_byte == gbt_pkg::CAP_TAU);
	assign accept = push && !q_full;

	always_comb begin
		txt      = gbt_pkg::map_text(in_byte);
		rel      = 1'b0;
		rel_char = 8'd0;
		case (held_q)
			HELD_SMALL_MU: begin
				if (is_pi) txt = gbt_pkg::txt1("b");
				else begin
					rel      = 1'b1;
					rel_char = "m";
				end
			end
			HELD_CAP_MU: begin
				if (is_pi) txt = gbt_pkg::txt1("B");
				else begin
					rel      = 1'b1;
					rel_char = "M";
				end
			end
			HELD_SMALL_NU: begin
				if (is_tau) txt = gbt_pkg::txt1("d");
				else begin
					rel      = 1'b1;
					rel_char = "n";
				end
			end
			HELD_CAP_NU: begin
				if (is_tau) txt = gbt_pkg::txt1("D");
				else begin
					rel      = 1'b1;
					rel_char = "N";
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		takes_hold = 1'b1;
		case (in_byte)
			gbt_pkg::CAP_MU:   held_next = HELD_CAP_MU;
			gbt_pkg::CAP_NU:   held_next = HELD_CAP_NU;
			gbt_pkg::SMALL_MU: held_next = HELD_SMALL_MU;
			gbt_pkg::SMALL_NU: held_next = HELD_SMALL_NU;
			default: begin
				held_next  = HELD_NONE;
				takes_hold = 1'b0;
			end
		endcase
	end

	// Released letter leads the run, then the text of this byte unless it is held back.
	always_comb begin
		q_data.cnt = {2'b00, rel} + (takes_hold ? 3'd0 : {1'b0, txt.len});
		if (rel) begin
			q_data.chr[0] = rel_char;
			q_data.chr[1] = txt.chr[0];
			q_data.chr[2] = txt.chr[1];
			q_data.chr[3] = txt.chr[2];
		end else begin
			q_data.chr[0] = txt.chr[0];
			q_data.chr[1] = txt.chr[1];
			q_data.chr[2] = txt.chr[2];
			q_data.chr[3] = 8'd0;
		end
	end

	assign q_push = accept && !ctrl && (q_data.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
		end else if (accept && !ctrl) begin
			held_q <= held_next;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/gbt_queue.sv
`default_nettype none
`include "greek_byte_transliterator_unit_macros.svh"
module gbt_queue #(
	parameter int DEPTH = gbt_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  gbt_pkg::run_t      wr_data,
	output logic               full,
	output logic               rd_valid,
	input  wire logic          rd_en,
	output gbt_pkg::run_t      rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gbt_pkg::run_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_rd) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	`GBT_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count overflow")
	`GBT_ASSERT_NEXT(a_cnt_rise, clk, arst_n, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "queue count did not advance on write")

endmodule
`default_nettype wire

>>> rtl/core/gbt_back.sv
`default_nettype none
`include "greek_byte_transliterator_unit_macros.svh"
module gbt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  gbt_pkg::run_t      q_data,
	output logic               q_pop,
	output logic               empty,
	input  wire logic          pop,
	output logic [7:0]         out_char,
	output logic               last_char
);

	gbt_pkg::run_t  run_q;
	logic [1:0]     idx_q;
	logic           busy_q;
	logic           out_valid_q;
	logic [7:0]     out_char_q;
	logic           last_q;
	logic           out_ld;
	logic           emit;
	logic           last_w;
	logic           work_free;

	assign out_ld    = !out_valid_q || pop;
	assign emit      = busy_q && out_ld;
	assign last_w    = ({1'b0, idx_q} + 3'd1) == run_q.cnt;
	assign work_free = !busy_q || (emit && last_w);
	assign q_pop     = q_valid && work_free;

	assign empty     = !out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (emit && last_w) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) run_q <= q_data;
		if (emit) begin
			out_char_q <= run_q.chr[idx_q];
			last_q     <= last_w;
		end
	end

	`GBT_ASSERT_NOW(a_idx_in_run, clk, arst_n, busy_q, {1'b0, idx_q} < run_q.cnt, "run index past run length")
	`GBT_ASSERT_NEXT(a_last_flag, clk, arst_n, emit && last_w, out_valid_q && last_q, "final item of run not flagged")

endmodule
`default_nettype wire

>>> rtl/core/greek_byte_transliterator_unit.sv
// ISO-8859-7 to Latin transliterator.
// Input channel: in_byte is taken when push is high and full is low.
// Result channel: while empty is low, out_char/last_char show the oldest item;
// it is taken when pop is high. last_char marks the final item of a byte's run.
// Each byte yields zero to four items: bytes below 32 and a mu or nu that is
// held back yield none; a held mu/nu is released ahead of the next byte or
// merged with a following pi/tau into b/B or d/D.
// A run's first item passes the run queue, run register and output register.
// Throughput: the input side takes one byte per cycle while the run queue has
// room; the output side delivers one item per cycle while the receiver keeps
// popping and runs are waiting in the queue.
// A stalled receiver holds the output register; the run queue then fills and
// full rises, with no item lost.
// Reset clears the held letter, the run queue and the output register.
`default_nettype none
module greek_byte_transliterator_unit #(
	parameter int QUEUE_DEPTH = gbt_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_char,
	output logic             last_char
);

	gbt_pkg::run_t  fq_data;
	gbt_pkg::run_t  qb_data;
	logic           fq_push;
	logic           qb_valid;
	logic           qb_pop;

	gbt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.q_full  (full),
		.q_push  (fq_push),
		.q_data  (fq_data)
	);

	gbt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fq_push),
		.wr_data  (fq_data),
		.full     (full),
		.rd_valid (qb_valid),
		.rd_en    (qb_pop),
		.rd_data  (qb_data)
	);

	gbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_data    (qb_data),
		.q_pop     (qb_pop),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule
`default_nettype wire
